// ===== sv/hidmp_pkg.sv =====
package hidmp_pkg;

	localparam logic [1:0] REG_CLASS    = 2'd0;
	localparam logic [1:0] REG_SUBCLASS = 2'd1;
	localparam logic [1:0] REG_PROTOCOL = 2'd2;

	localparam logic [7:0] RST_CLASS    = 8'h03;
	localparam logic [7:0] RST_SUBCLASS = 8'h01;
	localparam logic [7:0] RST_PROTOCOL = 8'h02;

	localparam logic [7:0] DESC_INTERFACE = 8'h04;
	localparam logic [7:0] DESC_ENDPOINT  = 8'h05;
	localparam logic [7:0] IFACE_NONE     = 8'hFF;
	localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
	localparam logic [7:0] EP_MIN_LEN     = 8'd7;
	localparam logic [1:0] XFER_INTERRUPT = 2'b11;
	localparam logic [3:0] STREAM_SAT     = 4'd9;
	localparam logic [3:0] CFG_BYTE_POS   = 4'd5;

	typedef struct packed {
		logic [7:0] match_class;
		logic [7:0] match_subclass;
		logic [7:0] match_protocol;
	} match_cfg_t;

	typedef struct packed {
		logic [3:0]  stream_count;
		logic [7:0]  desc_offset;
		logic [7:0]  desc_length;
		logic [7:0]  desc_kind;
		logic [7:0]  cur_interface;
		logic [23:0] cur_class_triple;
		logic [31:0] endpoint_fields;
		logic [7:0]  cfg_byte;
		logic        stopped;
		logic        m_found;
		logic [7:0]  m_interface;
		logic [3:0]  m_endpoint;
		logic [15:0] m_max_packet;
	} parse_state_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  config_value;
		logic [7:0]  interface_number;
		logic [3:0]  endpoint_number;
		logic [15:0] max_packet;
	} parse_result_t;

	localparam parse_state_t STATE_CLEAR = '{
		stream_count: 4'd0,
		desc_offset: 8'd0,
		desc_length: 8'd0,
		desc_kind: 8'd0,
		cur_interface: IFACE_NONE,
		cur_class_triple: 24'd0,
		endpoint_fields: 32'd0,
		cfg_byte: 8'd0,
		stopped: 1'b0,
		m_found: 1'b0,
		m_interface: 8'd0,
		m_endpoint: 4'd0,
		m_max_packet: 16'd0
	};

endpackage

// ===== sv/hidmp_if.sv =====
interface hidmp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface hidmp_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [7:0]  config_value;
	logic [7:0]  interface_number;
	logic [3:0]  endpoint_number;
	logic [15:0] max_packet;

	modport source (output valid, output found, output config_value,
		output interface_number, output endpoint_number, output max_packet,
		input ready);
	modport sink (input valid, input found, input config_value,
		input interface_number, input endpoint_number, input max_packet,
		output ready);
endinterface

// ===== sv/hid_mouse_endpoint_descriptor_parser_unit.sv =====
// Walks a USB configuration descriptor set arriving one byte per transfer and reports, on
// the byte flagged final, whether an interrupt IN endpoint with a non-zero packet size was
// found under an interface whose class, subclass and protocol match the three match
// registers (HID boot mouse after reset), together with the configuration value, interface
// number, endpoint number and max packet size. A byte is registered on input and parsed in
// the following cycle, so one byte is taken every cycle and its result is registered
// at the output; the input stalls only while a final byte waits on a result not yet taken.
module hid_mouse_endpoint_descriptor_parser_unit
	import hidmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	hidmp_in_if.sink    in_ch,
	hidmp_out_if.source out_ch
);

	match_cfg_t    cfg_q;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          fin_s1;
	logic          advance;
	parse_state_t  state_q;
	parse_state_t  state_next;
	parse_result_t result;
	parse_result_t result_q;
	logic          out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{match_class: RST_CLASS, match_subclass: RST_SUBCLASS,
				match_protocol: RST_PROTOCOL};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLASS: cfg_q.match_class <= cfg_data;
				REG_SUBCLASS: cfg_q.match_subclass <= cfg_data;
				REG_PROTOCOL: cfg_q.match_protocol <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!fin_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			fin_s1 <= in_ch.final_byte;
		end
	end

	hidmp_parse u_parse (
		.state      (state_q),
		.cfg        (cfg_q),
		.data_byte  (byte_s1),
		.final_byte (fin_s1),
		.next_state (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && fin_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fin_s1) begin
			result_q <= result;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.found = result_q.found;
	assign out_ch.config_value = result_q.config_value;
	assign out_ch.interface_number = result_q.interface_number;
	assign out_ch.endpoint_number = result_q.endpoint_number;
	assign out_ch.max_packet = result_q.max_packet;

endmodule

// ===== sv/hidmp_parse.sv =====
module hidmp_parse
	import hidmp_pkg::*;
(
	input  parse_state_t  state,
	input  match_cfg_t    cfg,
	input  logic [7:0]    data_byte,
	input  logic          final_byte,
	output parse_state_t  next_state,
	output parse_result_t result
);

	logic [7:0]   k;
	logic [7:0]   len_n;
	logic [7:0]   kind_n;
	logic [31:0]  ef_n;
	logic         halt;
	logic         iface_ok;
	parse_state_t nx;

	always_comb begin
		k = state.desc_offset;
		nx = state;
		len_n = state.desc_length;
		kind_n = state.desc_kind;
		ef_n = state.endpoint_fields;
		halt = 1'b0;
		iface_ok = 1'b0;

		if (state.stream_count == CFG_BYTE_POS) begin
			nx.cfg_byte = data_byte;
		end
		if (state.stream_count < STREAM_SAT) begin
			nx.stream_count = state.stream_count + 4'd1;
		end

		if (!state.stopped && !state.m_found) begin
			if (k == 8'd0) begin
				if (data_byte == 8'd0) begin
					halt = 1'b1;
				end else begin
					len_n = data_byte;
					kind_n = 8'd0;
					ef_n = 32'd0;
				end
			end else if (k == 8'd1) begin
				kind_n = data_byte;
			end else if (state.desc_kind == DESC_ENDPOINT) begin
				case (k)
					8'd2: ef_n[7:0] = data_byte;
					8'd3: ef_n[15:8] = data_byte;
					8'd4: ef_n[23:16] = data_byte;
					8'd5: ef_n[31:24] = data_byte;
					default: ;
				endcase
			end else if (state.desc_kind == DESC_INTERFACE) begin
				case (k)
					8'd2: ef_n[7:0] = data_byte;
					8'd5: ef_n[15:8] = data_byte;
					8'd6: ef_n[23:16] = data_byte;
					8'd7: ef_n[31:24] = data_byte;
					default: ;
				endcase
			end

			if (halt) begin
				nx.stopped = 1'b1;
			end else begin
				nx.desc_length = len_n;
				nx.desc_kind = kind_n;
				nx.endpoint_fields = ef_n;
				if (({1'b0, k} + 9'd1) >= {1'b0, len_n}) begin
					nx.desc_offset = 8'd0;
					if (kind_n == DESC_INTERFACE && len_n >= IFACE_MIN_LEN) begin
						nx.cur_interface = ef_n[7:0];
						nx.cur_class_triple = ef_n[31:8];
					end else if (kind_n == DESC_ENDPOINT && len_n >= EP_MIN_LEN) begin
						iface_ok = state.cur_interface != IFACE_NONE &&
							state.cur_class_triple[7:0] == cfg.match_class &&
							state.cur_class_triple[15:8] == cfg.match_subclass &&
							state.cur_class_triple[23:16] == cfg.match_protocol;
						if (iface_ok && ef_n[7] && ef_n[9:8] == XFER_INTERRUPT &&
							ef_n[31:16] != 16'd0) begin
							nx.m_found = 1'b1;
							nx.m_interface = state.cur_interface;
							nx.m_endpoint = ef_n[3:0];
							nx.m_max_packet = ef_n[31:16];
						end
					end
				end else begin
					nx.desc_offset = k + 8'd1;
				end
			end
		end

		result.found = nx.m_found && nx.stream_count == STREAM_SAT;
		result.config_value = result.found ? nx.cfg_byte : 8'd0;
		result.interface_number = result.found ? nx.m_interface : 8'd0;
		result.endpoint_number = result.found ? nx.m_endpoint : 4'd0;
		result.max_packet = result.found ? nx.m_max_packet : 16'd0;

		next_state = final_byte ? STATE_CLEAR : nx;
	end

endmodule

// ===== sv/hidmp_checker.sv =====
module hidmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [7:0]  config_value,
	input logic [7:0]  interface_number,
	input logic [3:0]  endpoint_number,
	input logic [15:0] max_packet
);

	// A result that is not taken must hold its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({found, config_value,
			interface_number, endpoint_number, max_packet}))
		else $error("result changed while stalled");

	// A not-found result carries all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> config_value == 8'd0 && interface_number == 8'd0 &&
			endpoint_number == 4'd0 && max_packet == 16'd0)
		else $error("not-found result has non-zero fields");

	// A match always has a non-zero packet size.
	a_hit_mps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> max_packet != 16'd0)
		else $error("match with zero max packet size");

	// Interface number 255 means no interface and can never match.
	a_hit_iface: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> interface_number != 8'hFF)
		else $error("match reported under no interface");

endmodule

bind hid_mouse_endpoint_descriptor_parser_unit hidmp_checker u_hidmp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.found            (out_ch.found),
	.config_value     (out_ch.config_value),
	.interface_number (out_ch.interface_number),
	.endpoint_number  (out_ch.endpoint_number),
	.max_packet       (out_ch.max_packet)
);
